// ===== src/ktq_pkg.sv =====
// Shared types and constants of the keyed table with min/max query unit.
package ktq_pkg;

  localparam int MaxEntries = 64;
  localparam int SlotW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [21:0] id;
    logic [39:0] res;
    logic [39:0] peak;
    logic [31:0] score;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_SCAN,
    S_DONE
  } state_t;

  // Control from the sequencer to every cell for one cycle.
  typedef struct packed {
    logic shift;     // rotate entries one cell towards the head
    logic wr;        // write wr_data into the cell at wr_slot
    logic [SlotW-1:0] wr_slot;
    logic clr;       // clear the cell at clr_slot
    logic [SlotW-1:0] clr_slot;
  } cell_ctl_t;

endpackage

// ===== src/ktq_cell.sv =====
// One table cell: holds an entry, passes it to its neighbour on a rotate.
module ktq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ktq_pkg::cell_ctl_t ctl,
  input  logic [ktq_pkg::SlotW-1:0] my_slot,
  input  ktq_pkg::entry_t   wr_data,
  input  ktq_pkg::entry_t   from_next,
  output ktq_pkg::entry_t   entry
);
  import ktq_pkg::*;

  entry_t entry_r, entry_nxt;

  // Select rotate, write or clear for this cell.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = from_next;
    end else if (ctl.wr && ctl.wr_slot == my_slot) begin
      entry_nxt = wr_data;
    end else if (ctl.clr && ctl.clr_slot == my_slot) begin
      entry_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
endmodule

// ===== src/keyed_table_with_min_max_query_unit.sv =====
// Top level of the keyed table with min/max query unit.
// Each request makes two full turns of a ring of cells: the entries sit in a
// ring that rotates one place a cycle past a single compare point at the head
// cell, once for the key search and once for the lowest/highest score scan
// after the update. The result is held in an output register; a new request is
// accepted once that result has been taken.
module keyed_table_with_min_max_query_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [21:0] in_key_id,
  input  logic [39:0] in_resident_kb,
  input  logic [39:0] in_peak_kb,
  input  logic signed [31:0] in_rank_score,
  input  logic [31:0] in_stamp_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic signed [6:0] out_hit_slot,
  output logic [39:0] out_found_resident_kb,
  output logic [39:0] out_found_peak_kb,
  output logic signed [31:0] out_found_score,
  output logic [31:0] out_found_stamp,
  output logic [6:0]  out_entry_count,
  output logic signed [6:0] out_lowest_slot,
  output logic signed [6:0] out_highest_slot
);
  import ktq_pkg::*;

  entry_t    cells [MaxEntries];
  cell_ctl_t ctl;
  entry_t    wr_data;

  state_t state_r, state_nxt;
  logic [SlotW-1:0] step_r, step_nxt;       // rotation count, head holds slot step_r
  logic [CntW-1:0]  count_r, count_nxt;
  logic [1:0]  op_r;
  entry_t      req_r;
  entry_t      found_r, found_nxt;           // entry seen at the head on a key match
  entry_t      last_r, last_nxt;             // entry seen at the head in the last used slot
  logic        hit_r, hit_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [SlotW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0] lo_k_r, lo_k_nxt, hi_k_r, hi_k_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        last_step;

  // Ring of cells: each takes its upper neighbour, the last takes the head.
  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    ktq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .my_slot(SlotW'(g)), .wr_data(wr_data),
      .from_next(cells[(g + 1) % MaxEntries]),
      .entry(cells[g])
    );
  end

  assign last_step = ({1'b0, step_r} == CntW'(MaxEntries - 1));
  assign in_ready = (state_r == S_IDLE) && !out_valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid && in_ready) state_nxt = S_SEARCH;
      S_SEARCH: if (last_step) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_SCAN;
      S_SCAN:   if (last_step) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    logic [31:0] k;
    logic in_use;
    k = cells[0].score ^ 32'h8000_0000;
    in_use = ({1'b0, step_r} < count_r);
    ctl = '0;
    wr_data = req_r;
    step_nxt = step_r;
    count_nxt = count_r;
    hit_nxt = hit_r;
    slot_nxt = slot_r;
    found_nxt = found_r;
    last_nxt = last_r;
    lo_nxt = lo_r; hi_nxt = hi_r; lo_k_nxt = lo_k_r; hi_k_nxt = hi_k_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        hit_nxt = 1'b0;
      end
      S_SEARCH: begin
        // Compare the head entry, first match wins, then rotate.
        if (in_use && !hit_r && cells[0].id == req_r.id) begin
          hit_nxt = 1'b1;
          slot_nxt = step_r;
          found_nxt = cells[0];
        end
        // Keep the last used entry for a remove.
        if (in_use && {1'b0, step_r} == count_r - 1'b1) begin
          last_nxt = cells[0];
        end
        ctl.shift = 1'b1;
        step_nxt = step_r + 1'b1;
      end
      S_APPLY: begin
        status_nxt = ST_OK;
        unique case (op_r)
          OP_UPSERT: begin
            if (hit_r) begin
              ctl.wr = 1'b1;
              ctl.wr_slot = slot_r;
            end else if (count_r >= CntW'(MaxEntries)) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.wr = 1'b1;
              ctl.wr_slot = count_r[SlotW-1:0];
              hit_nxt = 1'b1;
              slot_nxt = count_r[SlotW-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (!hit_r) begin
              status_nxt = ST_MISS;
            end else begin
              // Move the last entry down, clear the last slot.
              ctl.wr = 1'b1;
              ctl.wr_slot = slot_r;
              wr_data = last_r;
              ctl.clr = (slot_r != SlotW'(count_r - 1'b1));
              ctl.clr_slot = SlotW'(count_r - 1'b1);
              if (slot_r == SlotW'(count_r - 1'b1)) begin
                wr_data = '0;
              end
              count_nxt = count_r - 1'b1;
            end
          end
          OP_LOOKUP: if (!hit_r) status_nxt = ST_MISS;
          default: ;
        endcase
        step_nxt = '0;
        lo_nxt = '0; hi_nxt = '0;
        lo_k_nxt = 32'hFFFF_FFFF; hi_k_nxt = '0;
      end
      S_SCAN: begin
        // Track strict minimum and maximum of in-use slots, then rotate.
        if (in_use) begin
          if (step_r == '0 || k < lo_k_r) begin lo_nxt = step_r; lo_k_nxt = k; end
          if (step_r == '0 || k > hi_k_r) begin hi_nxt = step_r; hi_k_nxt = k; end
        end
        ctl.shift = 1'b1;
        step_nxt = step_r + 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      count_r <= '0;
      hit_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      count_r <= count_nxt;
      hit_r <= hit_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state_r == S_DONE) out_valid <= 1'b1;
    end
  end

  // Request and working payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_opcode;
      req_r <= '{id: in_key_id, res: in_resident_kb, peak: in_peak_kb,
                 score: in_rank_score, stamp: in_stamp_seconds};
    end
    slot_r <= slot_nxt;
    found_r <= found_nxt;
    last_r <= last_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; lo_k_r <= lo_k_nxt; hi_k_r <= hi_k_nxt;
    status_r <= status_nxt;
  end

  // Load the result register.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      logic look;
      look = (op_r == OP_LOOKUP) && hit_r;
      out_status <= status_r;
      out_hit_slot <= (hit_r && op_r != OP_NOP) ? 7'({1'b0, slot_r}) : 7'h7F;
      out_found_resident_kb <= look ? found_r.res : '0;
      out_found_peak_kb <= look ? found_r.peak : '0;
      out_found_score <= look ? found_r.score : '0;
      out_found_stamp <= look ? found_r.stamp : '0;
      out_entry_count <= 7'(count_r);
      out_lowest_slot <= (count_r == '0) ? 7'h7F : 7'({1'b0, lo_r});
      out_highest_slot <= (count_r == '0) ? 7'h7F : 7'({1'b0, hi_r});
    end
  end
endmodule

// ===== verif/tb_keyed_table_with_min_max_query_unit.sv =====
// Self-checking testbench for the keyed table with min/max query unit.
module tb_keyed_table_with_min_max_query_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ktq_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  hit;
    logic [39:0] res;
    logic [39:0] peak;
    logic [31:0] score;
    logic [31:0] stamp;
    logic [6:0]  count;
    logic [6:0]  lo;
    logic [6:0]  hi;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [21:0] in_key_id = '0;
  logic [39:0] in_resident_kb = '0;
  logic [39:0] in_peak_kb = '0;
  logic signed [31:0] in_rank_score = '0;
  logic [31:0] in_stamp_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [6:0] out_hit_slot;
  logic [39:0] out_found_resident_kb;
  logic [39:0] out_found_peak_kb;
  logic signed [31:0] out_found_score;
  logic [31:0] out_found_stamp;
  logic [6:0] out_entry_count;
  logic signed [6:0] out_lowest_slot;
  logic signed [6:0] out_highest_slot;

  // Shadow copy of the table
  logic [21:0] ids [MaxEntries];
  logic [39:0] residents [MaxEntries];
  logic [39:0] peaks [MaxEntries];
  logic signed [31:0] scores [MaxEntries];
  logic [31:0] stamps [MaxEntries];
  int used;

  table_reply_t pending_replies[$];
  int errors = 0;
  int cycles = 0;
  bit drain = 1'b0;

  keyed_table_with_min_max_query_unit dut (.*);

  always #2 clk = ~clk;

  // Abort on a runaway run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Apply one request to the shadow table and return the reply it causes
  function automatic table_reply_t apply_request(input logic [1:0] op, input logic [21:0] key,
      input logic [39:0] res, input logic [39:0] pk, input logic [31:0] sc,
      input logic [31:0] st);
    table_reply_t r;
    int slot;
    int last;
    r = '0;
    r.hit = 7'h7F;
    slot = -1;
    for (int i = 0; i < used; i++)
      if (slot < 0 && ids[i] == key) slot = i;
    case (op)
      OP_UPSERT: begin
        if (slot < 0) begin
          if (used >= MaxEntries) r.status = ST_FULL;
          else begin
            slot = used;
            ids[used] = key;
            used++;
          end
        end
        if (slot >= 0) begin
          residents[slot] = res;
          peaks[slot] = pk;
          scores[slot] = sc;
          stamps[slot] = st;
          r.hit = 7'(slot);
        end
      end
      OP_REMOVE: begin
        if (slot < 0) r.status = ST_MISS;
        else begin
          last = used - 1;
          ids[slot] = ids[last];
          residents[slot] = residents[last];
          peaks[slot] = peaks[last];
          scores[slot] = scores[last];
          stamps[slot] = stamps[last];
          ids[last] = '0;
          residents[last] = '0;
          peaks[last] = '0;
          scores[last] = '0;
          stamps[last] = '0;
          used = last;
          r.hit = 7'(slot);
        end
      end
      OP_LOOKUP: begin
        if (slot < 0) r.status = ST_MISS;
        else begin
          r.hit = 7'(slot);
          r.res = residents[slot];
          r.peak = peaks[slot];
          r.score = scores[slot];
          r.stamp = stamps[slot];
        end
      end
      default: ;
    endcase
    r.count = 7'(used);
    r.lo = 7'h7F;
    r.hi = 7'h7F;
    if (used > 0) begin
      int lo_i;
      int hi_i;
      lo_i = 0;
      hi_i = 0;
      for (int i = 1; i < used; i++) begin
        if (scores[i] < scores[lo_i]) lo_i = i;
        if (scores[i] > scores[hi_i]) hi_i = i;
      end
      r.lo = 7'(lo_i);
      r.hi = 7'(hi_i);
    end
    return r;
  endfunction

  // Send one request after a random gap
  task automatic send_request(input logic [1:0] op, input logic [21:0] key,
      input logic [39:0] res, input logic [39:0] pk, input logic [31:0] sc,
      input logic [31:0] st);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_id <= key;
    in_resident_kb <= res;
    in_peak_kb <= pk;
    in_rank_score <= sc;
    in_stamp_seconds <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(apply_request(op, key, res, pk, sc, st));
    @(negedge clk);
    in_valid <= 1'b0;
    // Drop valid before the next request is driven
    @(negedge clk);
  endtask

  // Randomise backpressure on the result side
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = drain ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    table_reply_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report("unexpected reply", 0, 0);
      end else begin
        w = pending_replies.pop_front();
        if (out_status != w.status) report("status", out_status, w.status);
        if (out_hit_slot != w.hit) report("hit_slot", out_hit_slot, w.hit);
        if (out_found_resident_kb != w.res) report("resident", out_found_resident_kb, w.res);
        if (out_found_peak_kb != w.peak) report("peak", out_found_peak_kb, w.peak);
        if (out_found_score != w.score) report("score", out_found_score, w.score);
        if (out_found_stamp != w.stamp) report("stamp", out_found_stamp, w.stamp);
        if (out_entry_count != w.count) report("count", out_entry_count, w.count);
        if (out_lowest_slot != w.lo) report("lowest", out_lowest_slot, w.lo);
        if (out_highest_slot != w.hi) report("highest", out_highest_slot, w.hi);
      end
    end
  end

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Key pool kept small so hits dominate
  function automatic logic [21:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 22'($urandom);
      1: return 22'h3FFFFF;
      2: return '0;
      default: return 22'($urandom_range(1, 80));
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // Extremes, misses on an empty table, unused opcode
  task automatic test_directed();
    send_request(OP_LOOKUP, 22'd5, '0, '0, '0, '0);
    send_request(OP_REMOVE, 22'd5, '0, '0, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1, '1, '1);
    send_request(OP_UPSERT, '0, '1, '1, 32'sh7FFFFFFF, '1);
    send_request(OP_UPSERT, '1, '0, '0, 32'sh80000000, '0);
    send_request(OP_UPSERT, 22'd7, 40'h5555555555, 40'hAAAAAAAAAA, '0, 32'hA5A5A5A5);
    send_request(OP_UPSERT, 22'd8, '0, '0, 32'sh80000000, '0);
    send_request(OP_LOOKUP, '0, '0, '0, '0, '0);
    send_request(OP_LOOKUP, '1, '0, '0, '0, '0);
    send_request(OP_UPSERT, 22'd7, '1, '0, 32'sh7FFFFFFF, '1);
    send_request(OP_LOOKUP, 22'd7, '0, '0, '0, '0);
    send_request(OP_UNUSED, 22'd7, '0, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, '0, '0, '0);
    send_request(OP_REMOVE, 22'd99, '0, '0, '0, '0);
    send_request(OP_LOOKUP, 22'd8, '0, '0, '0, '0);
    send_request(OP_REMOVE, 22'd8, '0, '0, '0, '0);
  endtask

  // Fill the table, hit the full case, then empty it again
  task automatic test_full_table();
    for (int i = 0; i < MaxEntries + 2; i++)
      send_request(OP_UPSERT, 22'(1000 + i), rand40(), rand40(), $urandom, $urandom);
    send_request(OP_UPSERT, 22'd1000, '0, '0, '0, '0);
    wait_idle();
    for (int i = MaxEntries - 1; i >= 0; i--)
      send_request(OP_REMOVE, 22'(1000 + (i * 7) % MaxEntries), '0, '0, '0, '0);
    send_request(OP_LOOKUP, 22'd1000, '0, '0, '0, '0);
  endtask

  // Random mix weighted towards hits on a live key pool
  task automatic test_random(input int n);
    logic [1:0] op;
    logic [31:0] sc;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = OP_UPSERT;
        4, 5: op = OP_REMOVE;
        9: op = 2'($urandom);
        default: op = OP_LOOKUP;
      endcase
      // Narrow scores often to force ties
      sc = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 3)) - 32'd1 : $urandom;
      send_request(op, pick_key(), rand40(), rand40(), sc, $urandom);
      if (i == n / 2) wait_idle();
    end
  endtask

  initial begin
    used = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      ids[i] = '0;
      residents[i] = '0;
      peaks[i] = '0;
      scores[i] = '0;
      stamps[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random(1550);
    wait_idle();
    drain = 1'b1;
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
